@@ rtl/core/aes128_pkg.sv @@
// Shared types, constants and byte- and block-level functions for the AES-128 block engine.
package aes128_pkg;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ENCRYPT = 2'd1;
    localparam logic [1:0] FUNC_DECRYPT = 2'd2;

    localparam int BLOCK_BYTES = 16;

    typedef logic [127:0] block_t;

    // sideband that travels with a block through the round chain
    typedef struct packed {
        logic valid;
        logic dec;
    } tag_t;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[x];
    endfunction

    // byte n of a block sits at bits 127-8n -: 8
    function automatic logic [7:0] get_byte(input block_t b, input int n);
        get_byte = b[127 - 8*n -: 8];
    endfunction

    function automatic block_t sub_shift(input block_t b, input logic inverse);
        block_t o;
        int src;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inverse ? ((c + 4 - r) & 3) : ((c + r) & 3);
                o[127 - 8*(4*c + r) -: 8] = inverse ? inv_sbox(get_byte(b, 4*src + r))
                                                    : sbox(get_byte(b, 4*src + r));
            end
        end
        sub_shift = o;
    endfunction

    function automatic block_t mix(input block_t b, input logic inverse);
        block_t o;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(b, 4*c);
            a1 = get_byte(b, 4*c + 1);
            a2 = get_byte(b, 4*c + 2);
            a3 = get_byte(b, 4*c + 3);
            if (inverse) begin
                // preconditioning turns InvMixColumns into a forward mix
                u = xt(xt(a0 ^ a2));
                v = xt(xt(a1 ^ a3));
                a0 = a0 ^ u;
                a1 = a1 ^ v;
                a2 = a2 ^ u;
                a3 = a3 ^ v;
            end
            x0 = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            x1 = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            x2 = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            x3 = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            o[127 - 32*c -: 32] = {x0, x1, x2, x3};
        end
        mix = o;
    endfunction

endpackage

@@ rtl/core/aes128_cell.sv @@
// One round cell of the cipher chain: key add, mix and byte substitution, with registered block and tag.
module aes128_cell #(
    parameter int FIRST = 0,
    parameter int LAST  = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  aes128_pkg::tag_t      tag_in,
    input  aes128_pkg::block_t    blk_in,
    input  aes128_pkg::block_t    key_enc,
    input  aes128_pkg::block_t    key_dec,
    output aes128_pkg::tag_t      tag_out,
    output aes128_pkg::block_t    blk_out
);

    aes128_pkg::tag_t   tag_reg;
    aes128_pkg::block_t blk_reg;
    aes128_pkg::block_t blk_next;
    aes128_pkg::block_t enc_v;
    aes128_pkg::block_t dec_v;

    // encrypt round: SubBytes/ShiftRows, MixColumns unless last, AddRoundKey
    // first encrypt cell also adds the initial key
    // decrypt round: AddRoundKey, InvMix unless first, InvShift/InvSub; last decrypt cell also adds round 0 key
    always_comb begin
        aes128_pkg::block_t e0;
        aes128_pkg::block_t d0;
        e0 = (FIRST != 0) ? (blk_in ^ key_dec) : blk_in;
        e0 = aes128_pkg::sub_shift(e0, 1'b0);
        if (LAST == 0) begin
            e0 = aes128_pkg::mix(e0, 1'b0);
        end
        enc_v = e0 ^ key_enc;
        d0 = blk_in ^ key_dec;
        if (FIRST == 0) begin
            d0 = aes128_pkg::mix(d0, 1'b1);
        end
        d0 = aes128_pkg::sub_shift(d0, 1'b1);
        dec_v = (LAST != 0) ? (d0 ^ key_enc) : d0;
        blk_next = tag_in.dec ? dec_v : enc_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (adv) begin
            tag_reg <= tag_in;
        end
        if (adv) begin
            blk_reg <= blk_next;
        end
    end

    assign tag_out = tag_reg;
    assign blk_out = blk_reg;

endmodule

@@ rtl/core/aes128_block_cipher.sv @@
// Top level of the AES block engine: key store, round cell chain and output stall control.
//   channel | ports                                          | dir
//   input   | s_valid s_ready s_func s_key_word_index s_data_* | in
//   result  | m_valid m_ready m_block_out_* m_was_decrypt    | out
// One block enters per cycle unless the chain is stalled; its result leaves through the registered round cells.
// Loads write the key store and give no result.
// A load waits until the chain is empty, so blocks in flight keep the keys they started with.
// Reset clears only the chain tags (valid and decrypt bits); the key store holds garbage until loaded.
// The whole chain stalls when its last cell holds a result that m_ready does not take.
module aes128_block_cipher #(
    parameter int ROUNDS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [4:0]  s_key_word_index,
    input  logic [63:0] s_data_high,
    input  logic [63:0] s_data_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_block_out_high,
    output logic [63:0] m_block_out_low,
    output logic        m_was_decrypt
);

    localparam int KEY_WORDS = 2 * (ROUNDS + 1);

    logic [63:0] key_reg [KEY_WORDS];
    logic        adv;
    logic        acc;
    logic        blk_item;
    logic        busy;

    aes128_pkg::tag_t   tag_c [ROUNDS + 1];
    aes128_pkg::block_t blk_c [ROUNDS + 1];

    // any block still in the chain
    always_comb begin
        busy = 1'b0;
        for (int i = 1; i <= ROUNDS; i++) begin
            busy = busy || tag_c[i].valid;
        end
    end

    assign adv      = !tag_c[ROUNDS].valid || m_ready;
    assign s_ready  = adv && !(busy && (s_func == aes128_pkg::FUNC_LOAD));
    assign acc      = s_valid && s_ready;
    assign blk_item = (s_func == aes128_pkg::FUNC_ENCRYPT) ||
                      (s_func == aes128_pkg::FUNC_DECRYPT);

    assign tag_c[0].valid = acc && blk_item;
    assign tag_c[0].dec   = (s_func == aes128_pkg::FUNC_DECRYPT);
    assign blk_c[0]       = {s_data_high, s_data_low};

    always_ff @(posedge aclk) begin
        if (acc && (s_func == aes128_pkg::FUNC_LOAD) &&
            ({27'd0, s_key_word_index} < KEY_WORDS)) begin
            key_reg[s_key_word_index] <= s_data_high;
        end
    end

    // cell i does encrypt round i+1 and decrypt round ROUNDS-i
    for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
        localparam int ER = i + 1;
        localparam int DR = ROUNDS - i;
        aes128_pkg::block_t kenc;
        aes128_pkg::block_t kdec;
        // kdec doubles as round 0 key for the first encrypt cell; kenc as round 0 for the
        // last decrypt cell
        always_comb begin
            if (tag_c[i].dec) begin
                kdec = {key_reg[2*DR], key_reg[2*DR + 1]};
                kenc = {key_reg[0], key_reg[1]};
            end else begin
                kdec = {key_reg[0], key_reg[1]};
                kenc = {key_reg[2*ER], key_reg[2*ER + 1]};
            end
        end
        aes128_cell #(
            .FIRST(i == 0 ? 1 : 0),
            .LAST (i == ROUNDS - 1 ? 1 : 0)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .adv    (adv),
            .tag_in (tag_c[i]),
            .blk_in (blk_c[i]),
            .key_enc(kenc),
            .key_dec(kdec),
            .tag_out(tag_c[i + 1]),
            .blk_out(blk_c[i + 1])
        );
    end

    assign m_valid          = tag_c[ROUNDS].valid;
    assign m_was_decrypt    = tag_c[ROUNDS].dec;
    assign m_block_out_high = blk_c[ROUNDS][127:64];
    assign m_block_out_low  = blk_c[ROUNDS][63:0];

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_block_out_high))
        else $error("result changed while stalled");
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !busy |-> s_ready)
        else $error("chain blocked with empty output");
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && (s_func == aes128_pkg::FUNC_LOAD) |=> !tag_c[1].valid)
        else $error("load entered the round chain");
`endif

endmodule

@@ test/tb_aes128_block_cipher.sv @@
// Testbench for the AES-128 block engine: randomized load/encrypt/decrypt traffic with an in-bench cipher.
module tb_aes128_block_cipher;

    localparam int NUM_KEY_WORDS = 22;
    localparam logic [1:0] FUNC_NONE = 2'd3;   // unused code, ignored by the block
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [1:0]  func;
        logic [4:0]  idx;
        logic [63:0] hi;
        logic [63:0] lo;
        bit          drain;   // hold until the engine is empty
    } cmd_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        dec;
    } blk_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [4:0]  s_key_word_index;
    logic [63:0] s_data_high;
    logic [63:0] s_data_low;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_block_out_high;
    logic [63:0] m_block_out_low;
    logic        m_was_decrypt;

    aes128_block_cipher dut (.*);

    cmd_t        pending_items[$];
    blk_res_t    expected_blocks[$];
    logic [63:0] key_words[NUM_KEY_WORDS];
    logic [7:0]  sb[256];
    logic [7:0]  isb[256];
    int          errors = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          send_burst = 0;
    bit          recv_burst = 0;

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] rot8(logic [7:0] v, int s);
        return (v << s) | (v >> (8 - s));
    endfunction

    // S-box tables built from field inversion and the affine map
    task automatic build_sboxes();
        logic [7:0] inv, y;
        for (int x = 0; x < 256; x++) begin
            inv = 1;
            for (int i = 0; i < 254; i++) inv = gf_mul(inv, x[7:0]);
            y = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
            sb[x] = y;
            isb[y] = x[7:0];
        end
    endtask

    function automatic blk_res_t aes_block(logic [63:0] hi, logic [63:0] lo, logic dec);
        logic [7:0] st[16];
        logic [7:0] t[16];
        logic [7:0] col[4];
        logic [7:0] mf[4];
        logic [7:0] acc;
        int rnd, src;
        blk_res_t res;
        for (int n = 0; n < 8; n++) begin
            st[n]     = hi[63 - 8*n -: 8];
            st[n + 8] = lo[63 - 8*n -: 8];
        end
        if (dec) mf = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     mf = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int step = 0; step <= 10; step++) begin
            rnd = dec ? 10 - step : step;
            if (dec && step > 0) begin
                // inverse shift rows then inverse sub bytes
                t = st;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        src = (c + 4 - r) & 3;
                        st[4*c + r] = isb[t[4*src + r]];
                    end
            end
            if (!dec && step > 0) begin
                t = st;
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        src = (c + r) & 3;
                        st[4*c + r] = sb[t[4*src + r]];
                    end
                if (step != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int k = 0; k < 4; k++) col[k] = st[4*c + k];
                        for (int r = 0; r < 4; r++) begin
                            acc = 0;
                            for (int k = 0; k < 4; k++)
                                acc ^= gf_mul(mf[(k + 4 - r) & 3], col[k]);
                            st[4*c + r] = acc;
                        end
                    end
                end
            end
            // round key add
            for (int n = 0; n < 16; n++)
                st[n] ^= key_words[(16*rnd + n) / 8][63 - 8*((16*rnd + n) % 8) -: 8];
            if (dec && rnd != 10 && rnd != 0) begin
                for (int c = 0; c < 4; c++) begin
                    for (int k = 0; k < 4; k++) col[k] = st[4*c + k];
                    for (int r = 0; r < 4; r++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc ^= gf_mul(mf[(k + 4 - r) & 3], col[k]);
                        st[4*c + r] = acc;
                    end
                end
            end
        end
        for (int n = 0; n < 8; n++) begin
            res.hi[63 - 8*n -: 8] = st[n];
            res.lo[63 - 8*n -: 8] = st[n + 8];
        end
        res.dec = dec;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    task automatic push_cmd(logic [1:0] func, logic [4:0] idx, logic [63:0] hi,
                            logic [63:0] lo, bit drain);
        cmd_t c;
        c.func = func; c.idx = idx; c.hi = hi; c.lo = lo; c.drain = drain;
        pending_items.push_back(c);
    endtask

    // a full schedule reload waits for the engine to empty first
    task automatic push_key_schedule();
        for (int w = 0; w < NUM_KEY_WORDS; w++)
            push_cmd(aes128_pkg::FUNC_LOAD, w[4:0], rand64(), rand64(), w == 0);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // stimulus
    initial begin
        int sel;
        s_valid = 0; s_func = '0; s_key_word_index = '0;
        s_data_high = '0; s_data_low = '0; m_ready = 0;
        aresetn = 0;
        build_sboxes();
        for (int w = 0; w < NUM_KEY_WORDS; w++)
            push_cmd(aes128_pkg::FUNC_LOAD, w[4:0],
                     (w % 3 == 0) ? '1 : (w % 3 == 1) ? '0 : rand64(), rand64(), 0);
        push_cmd(aes128_pkg::FUNC_LOAD, 5'd22, '1, '1, 0);
        push_cmd(aes128_pkg::FUNC_LOAD, 5'd31, 64'h0123456789abcdef, '0, 0);
        push_cmd(FUNC_NONE, 5'd3, '1, '1, 0);
        push_cmd(aes128_pkg::FUNC_ENCRYPT, '0, '0, '0, 0);
        push_cmd(aes128_pkg::FUNC_ENCRYPT, '1, '1, '1, 0);
        push_cmd(aes128_pkg::FUNC_DECRYPT, '0, '0, '0, 0);
        push_cmd(aes128_pkg::FUNC_DECRYPT, '1, '1, '1, 0);
        push_cmd(aes128_pkg::FUNC_ENCRYPT, 5'd9, 64'h00112233_44556677,
                 64'h8899aabb_ccddeeff, 0);
        push_cmd(aes128_pkg::FUNC_DECRYPT, 5'd17, 64'h69c4e0d8_6a7b0430,
                 64'hd8cdb780_70b4c55a, 0);
        for (int i = 0; i < 290; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) push_key_schedule();
            else if (sel < 6)
                push_cmd(aes128_pkg::FUNC_LOAD, 5'($urandom_range(22, 31)), rand64(),
                         rand64(), 0);
            else if (sel < 9)
                push_cmd(FUNC_NONE, 5'($urandom()), rand64(), rand64(), 0);
            else
                push_cmd(sel[0] ? aes128_pkg::FUNC_ENCRYPT : aes128_pkg::FUNC_DECRYPT,
                         5'($urandom()), rand64(), rand64(), 0);
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        wait (pending_items.size() == 0 && !s_valid && expected_blocks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // input side: present the next item and drive m_ready at the falling edge
    always @(negedge aclk) begin
        if (aresetn && !s_valid && pending_items.size() != 0) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (!pending_items[0].drain || quiet_cycles >= DRAIN_CYCLES) begin
                s_func           <= pending_items[0].func;
                s_key_word_index <= pending_items[0].idx;
                s_data_high      <= pending_items[0].hi;
                s_data_low       <= pending_items[0].lo;
                s_valid          <= 1;
                void'(pending_items.pop_front());
            end
        end
        if (aresetn) begin
            if (recv_gap > 0) begin
                m_ready <= 0;
                recv_gap--;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // accept side and result checking at the rising edge
    always @(posedge aclk) begin
        blk_res_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                quiet_cycles <= 0;
                if (s_func == aes128_pkg::FUNC_LOAD) begin
                    if (s_key_word_index < NUM_KEY_WORDS)
                        key_words[s_key_word_index] = s_data_high;
                end else if (s_func == aes128_pkg::FUNC_ENCRYPT ||
                             s_func == aes128_pkg::FUNC_DECRYPT) begin
                    expected_blocks.push_back(aes_block(s_data_high, s_data_low,
                                                        s_func == aes128_pkg::FUNC_DECRYPT));
                end
                s_valid <= 0;
                if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 19);
            end else if (!s_valid && expected_blocks.size() == 0) begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected result", m_block_out_high, '0);
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_block_out_high !== want.hi)
                        report_mismatch("block_out_high", m_block_out_high, want.hi);
                    if (m_block_out_low !== want.lo)
                        report_mismatch("block_out_low", m_block_out_low, want.lo);
                    if (m_was_decrypt !== want.dec)
                        report_mismatch("was_decrypt", {63'd0, m_was_decrypt},
                                        {63'd0, want.dec});
                end
                if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 19);
            end
        end
    end

endmodule
